// ----- rtl/core/kemt_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kemt_pkg: shared types and constants for the Kirsch edge threshold block
// Sizes, opcodes, register indexes, queue entry and queue status types.
// ----------------------------------------------------------------------------
package kemt_pkg;

    localparam int MAX_WIDTH   = 512;
    localparam int MAX_HEIGHT  = 512;
    localparam int CFG_W       = 10;
    localparam int IDX_W       = 2;
    localparam int PIX_W       = 8;
    localparam int COL_W       = $clog2(MAX_WIDTH);
    localparam int ROW_W       = $clog2(MAX_HEIGHT);
    localparam int WD_W        = COL_W + 1;
    localparam int HT_W        = ROW_W + 1;
    localparam int STORE_DEPTH = MAX_WIDTH * MAX_HEIGHT;
    localparam int ADDR_W      = $clog2(STORE_DEPTH);
    localparam int SUM_W       = 11;
    localparam int RESP_W      = 12;
    localparam int PROD_W      = 25;
    localparam int QDEPTH      = 4;
    localparam int QPTR_W      = $clog2(QDEPTH);
    localparam int QCNT_W      = $clog2(QDEPTH + 1);

    // floor(x / 15) for x below 4096 as (x * 4370) >> 16
    localparam logic [PROD_W-1:0] DIV15_MUL = PROD_W'(4370);
    localparam int DIV15_SHIFT = 16;

    localparam logic [PIX_W-1:0] EDGE_VAL = 8'd0;
    localparam logic [PIX_W-1:0] BG_VAL   = 8'd255;

    localparam logic [IDX_W-1:0] REG_IMAGE_WIDTH  = 2'd0;
    localparam logic [IDX_W-1:0] REG_IMAGE_HEIGHT = 2'd1;

    typedef enum logic {
        OP_LOAD  = 1'b0,
        OP_FETCH = 1'b1
    } op_t;

    typedef struct packed {
        op_t               op;
        logic              restart;
        logic              calc;
        logic [ADDR_W-1:0] addr;
        logic              interior;
        logic              last;
    } kemt_tag_t;

    typedef struct packed {
        kemt_tag_t             tag;
        logic [7:0][PIX_W-1:0] nb;
    } kemt_entry_t;

    typedef struct packed {
        logic [QCNT_W-1:0] count;
        logic              full;
        logic              empty;
    } kemt_qstat_t;

    function automatic logic [WD_W-1:0] clamp_dim(input logic [CFG_W-1:0] v,
                                                  input logic [WD_W-1:0] maxv);
        logic [31:0] v32;
        logic [31:0] m32;
        v32 = 32'(v);
        m32 = 32'(maxv);
        if (v == '0) begin
            return WD_W'(1);
        end
        else if (v32 > m32) begin
            return maxv;
        end
        else begin
            return WD_W'(v);
        end
    endfunction

endpackage

// ----- rtl/core/kirsch_edge_midrange_threshold.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kirsch_edge_midrange_threshold: Kirsch compass edge map with mid-range cut
// Loads a grey image, stores per-pixel compass responses and reads back
// an edge map thresholded halfway between the lowest and highest response.
// ----------------------------------------------------------------------------
// Usage. Requests enter on the s_axis channel: tuser selects load (0) or
// fetch (1) and tdata carries the pixel for a load. Loads deliver the image in
// raster order; once the last pixel of a width by height image is in, fetch
// requests read the edge map back in raster order, one m_axis item each,
// with tlast on the final pixel; reading wraps to the start after that.
// A fetch sent before the image is complete is taken and dropped, and a load
// after completion starts a new image. The cfg channel writes image_width
// (index 0) or image_height (index 1) and restarts the image; it is meant
// to be used only while the block is idle and is always ready.
// Throughput is one request per cycle while the request queue has room. A fetch
// result passes from the front's line-buffer read stage into the queue, then
// through the response, maximum and divide stages of the back and its output register,
// which captures the frame-store read. When m_axis stalls, the back pipeline
// holds and the four-entry queue keeps taking requests until it fills. Reset
// restores both sizes to 512 and empties the pipeline; the frame store is
// not cleared.
// ----------------------------------------------------------------------------
module kirsch_edge_midrange_threshold
    import kemt_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    // Configuration write channel.
    input  logic              cfg_valid,
    output logic              cfg_ready,
    input  logic [IDX_W-1:0]  cfg_index,
    input  logic [CFG_W-1:0]  cfg_data,
    // Request stream.
    input  logic              s_axis_tvalid,
    output logic              s_axis_tready,
    input  logic [7:0]        s_axis_tdata,   // [7:0] pixel_value
    input  logic              s_axis_tuser,   // [0] opcode
    // Result stream.
    output logic              m_axis_tvalid,
    input  logic              m_axis_tready,
    output logic [7:0]        m_axis_tdata,   // [7:0] edge_pixel
    output logic              m_axis_tlast    // last_pixel
);

    logic        cfg_we;
    logic        q_push;
    logic        q_pop;
    kemt_entry_t q_din;
    kemt_entry_t q_dout;
    kemt_qstat_t q_stat;

    // The register file is always able to take a write.
    assign cfg_ready = 1'b1;
    assign cfg_we    = cfg_valid && cfg_ready;

    kemt_front u_front
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_idx   (cfg_index),
        .cfg_wdata (cfg_data),
        .in_valid  (s_axis_tvalid),
        .in_ready  (s_axis_tready),
        .in_op     (op_t'(s_axis_tuser)),
        .in_pix    (s_axis_tdata),
        .qstat     (q_stat),
        .push      (q_push),
        .entry     (q_din)
    );

    kemt_fifo u_fifo
    (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (q_push),
        .din   (q_din),
        .pop   (q_pop),
        .dout  (q_dout),
        .stat  (q_stat)
    );

    kemt_back u_back
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .qstat     (q_stat),
        .head      (q_dout),
        .pop       (q_pop),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .out_pix   (m_axis_tdata),
        .out_last  (m_axis_tlast)
    );

    // The front reserves queue space, so a push never meets a full queue.
    assert property (@(posedge clk) disable iff (!rst_n) q_push |-> !q_stat.full)
        else $error("request queue overflow");

    // The back only pops entries that are present.
    assert property (@(posedge clk) disable iff (!rst_n) q_pop |-> !q_stat.empty)
        else $error("request queue underflow");

    // A stalled result may not be overwritten by the pipeline behind it (checked on tlast).
    assert property (@(posedge clk) disable iff (!rst_n)
                     (m_axis_tvalid && !m_axis_tready) |=> $stable(m_axis_tlast))
        else $error("stalled result changed");

endmodule

// ----- rtl/core/kemt_fifo.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kemt_fifo: short request queue between front and back
// Register based, one push and one pop per cycle.
// ----------------------------------------------------------------------------
module kemt_fifo
    import kemt_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        push,
    input  kemt_entry_t din,
    input  logic        pop,
    output kemt_entry_t dout,
    output kemt_qstat_t stat
);

    kemt_entry_t       mem_reg [QDEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg;
    logic [QPTR_W-1:0] rd_ptr_reg;
    logic [QCNT_W-1:0] count_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            if (push && !pop)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (pop && !push)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= din;
        end
    end

    assign dout       = mem_reg[rd_ptr_reg];
    assign stat.count = count_reg;
    assign stat.full  = (count_reg == QCNT_W'(QDEPTH));
    assign stat.empty = (count_reg == '0);

endmodule

// ----- rtl/core/kemt_front.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kemt_front: request intake, raster tracking and 3x3 window forming
// Keeps the size registers, load and fetch positions, the two line buffers
// and the window columns, and queues one entry per request that has work.
// ----------------------------------------------------------------------------
module kemt_front
    import kemt_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cfg_we,
    input  logic [IDX_W-1:0]  cfg_idx,
    input  logic [CFG_W-1:0]  cfg_wdata,
    input  logic              in_valid,
    output logic              in_ready,
    input  op_t               in_op,
    input  logic [PIX_W-1:0]  in_pix,
    input  kemt_qstat_t       qstat,
    output logic              push,
    output kemt_entry_t       entry
);

    logic [CFG_W-1:0]  width_cfg_reg;
    logic [CFG_W-1:0]  height_cfg_reg;
    logic [ROW_W-1:0]  ld_row_reg;
    logic [COL_W-1:0]  ld_col_reg;
    logic [ADDR_W-1:0] ld_pos_reg;
    logic              complete_reg;
    logic [ROW_W-1:0]  fe_row_reg;
    logic [COL_W-1:0]  fe_col_reg;
    logic [ADDR_W-1:0] fe_pos_reg;

    logic              a_valid_reg;
    kemt_tag_t         a_tag_reg;
    logic [PIX_W-1:0]  a_pix_reg;
    logic [COL_W-1:0]  a_col_reg;
    logic [2*PIX_W-1:0] lb_rdata_reg;
    logic [2*PIX_W-1:0] lb_mem [MAX_WIDTH];
    logic [3*PIX_W-1:0] win1_reg;
    logic [3*PIX_W-1:0] win2_reg;

    logic [WD_W-1:0]   w;
    logic [HT_W-1:0]   h;
    logic              accept;
    logic              restart;
    logic [ROW_W-1:0]  row_cur;
    logic [COL_W-1:0]  col_cur;
    logic [ADDR_W-1:0] pos_cur;
    logic              row_end;
    logic              col_end;
    logic              fe_row_end;
    logic              fe_col_end;
    logic              fe_interior;
    logic [3*PIX_W-1:0] new_col;
    logic              a_load;

    assign w = clamp_dim(width_cfg_reg, WD_W'(MAX_WIDTH));
    assign h = clamp_dim(height_cfg_reg, HT_W'(MAX_HEIGHT));

    // Room is reserved for the request already in the line-buffer read stage.
    assign in_ready = (({1'b0, qstat.count} + (QCNT_W+1)'(a_valid_reg))
                       < (QCNT_W+1)'(QDEPTH));
    assign accept   = in_valid && in_ready;

    assign restart  = complete_reg;
    assign row_cur  = restart ? '0 : ld_row_reg;
    assign col_cur  = restart ? '0 : ld_col_reg;
    assign pos_cur  = restart ? '0 : ld_pos_reg;
    assign row_end  = ({1'b0, row_cur} == h - 1'b1);
    assign col_end  = ({1'b0, col_cur} == w - 1'b1);

    assign fe_row_end  = ({1'b0, fe_row_reg} == h - 1'b1);
    assign fe_col_end  = ({1'b0, fe_col_reg} == w - 1'b1);
    assign fe_interior = (w >= WD_W'(3)) && (h >= HT_W'(3))
                         && (fe_row_reg != '0) && ({1'b0, fe_row_reg} <= h - HT_W'(2))
                         && (fe_col_reg != '0) && ({1'b0, fe_col_reg} <= w - WD_W'(2));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_cfg_reg  <= CFG_W'(MAX_WIDTH);
            height_cfg_reg <= CFG_W'(MAX_HEIGHT);
            ld_row_reg     <= '0;
            ld_col_reg     <= '0;
            ld_pos_reg     <= '0;
            complete_reg   <= 1'b0;
            fe_row_reg     <= '0;
            fe_col_reg     <= '0;
            fe_pos_reg     <= '0;
            a_valid_reg    <= 1'b0;
        end
        else
        begin
            a_valid_reg <= accept && ((in_op == OP_LOAD) || complete_reg);
            if (cfg_we)
            begin
                if (cfg_idx == REG_IMAGE_WIDTH)
                begin
                    width_cfg_reg <= cfg_wdata;
                end
                if (cfg_idx == REG_IMAGE_HEIGHT)
                begin
                    height_cfg_reg <= cfg_wdata;
                end
                if ((cfg_idx == REG_IMAGE_WIDTH) || (cfg_idx == REG_IMAGE_HEIGHT))
                begin
                    ld_row_reg   <= '0;
                    ld_col_reg   <= '0;
                    ld_pos_reg   <= '0;
                    complete_reg <= 1'b0;
                    fe_row_reg   <= '0;
                    fe_col_reg   <= '0;
                    fe_pos_reg   <= '0;
                end
            end
            else if (accept && (in_op == OP_LOAD))
            begin
                ld_pos_reg   <= pos_cur + 1'b1;
                complete_reg <= row_end && col_end;
                if (col_end)
                begin
                    ld_col_reg <= '0;
                    ld_row_reg <= row_cur + 1'b1;
                end
                else
                begin
                    ld_col_reg <= col_cur + 1'b1;
                    ld_row_reg <= row_cur;
                end
                if (restart)
                begin
                    fe_row_reg <= '0;
                    fe_col_reg <= '0;
                    fe_pos_reg <= '0;
                end
            end
            else if (accept && complete_reg)
            begin
                if (fe_row_end && fe_col_end)
                begin
                    fe_row_reg <= '0;
                    fe_col_reg <= '0;
                    fe_pos_reg <= '0;
                end
                else if (fe_col_end)
                begin
                    fe_col_reg <= '0;
                    fe_row_reg <= fe_row_reg + 1'b1;
                    fe_pos_reg <= fe_pos_reg + 1'b1;
                end
                else
                begin
                    fe_col_reg <= fe_col_reg + 1'b1;
                    fe_pos_reg <= fe_pos_reg + 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            a_pix_reg <= in_pix;
            a_col_reg <= col_cur;
            a_tag_reg.op <= in_op;
            if (in_op == OP_LOAD)
            begin
                a_tag_reg.restart  <= restart;
                a_tag_reg.calc     <= (row_cur >= ROW_W'(2)) && (col_cur >= COL_W'(2));
                a_tag_reg.addr     <= pos_cur - ADDR_W'(w) - 1'b1;
                a_tag_reg.interior <= 1'b0;
                a_tag_reg.last     <= 1'b0;
            end
            else
            begin
                a_tag_reg.restart  <= 1'b0;
                a_tag_reg.calc     <= 1'b0;
                a_tag_reg.addr     <= fe_pos_reg;
                a_tag_reg.interior <= fe_interior;
                a_tag_reg.last     <= fe_row_end && fe_col_end;
            end
        end
    end

    // Line buffers: upper byte holds row r-2, lower byte row r-1.
    assign a_load  = a_valid_reg && (a_tag_reg.op == OP_LOAD);
    assign new_col = {lb_rdata_reg, a_pix_reg};

    always_ff @(posedge clk)
    begin
        if (accept && (in_op == OP_LOAD))
        begin
            lb_rdata_reg <= lb_mem[col_cur];
        end
        if (a_load)
        begin
            lb_mem[a_col_reg] <= {lb_rdata_reg[PIX_W-1:0], a_pix_reg};
            win2_reg <= win1_reg;
            win1_reg <= new_col;
        end
    end

    // Column words: [23:16] top, [15:8] middle, [7:0] bottom.
    assign push          = a_valid_reg;
    assign entry.tag     = a_tag_reg;
    assign entry.nb[0]   = new_col[15:8];
    assign entry.nb[1]   = new_col[23:16];
    assign entry.nb[2]   = win1_reg[23:16];
    assign entry.nb[3]   = win2_reg[23:16];
    assign entry.nb[4]   = win2_reg[15:8];
    assign entry.nb[5]   = win2_reg[7:0];
    assign entry.nb[6]   = win1_reg[7:0];
    assign entry.nb[7]   = new_col[7:0];

endmodule

// ----- rtl/core/kemt_back.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kemt_back: compass responses, frame store and thresholded read-out
// Four-stage pipeline that advances as a whole unless the output is stalled.
// ----------------------------------------------------------------------------
module kemt_back
    import kemt_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             cfg_we,
    input  kemt_qstat_t      qstat,
    input  kemt_entry_t      head,
    output logic             pop,
    output logic             out_valid,
    input  logic             out_ready,
    output logic [PIX_W-1:0] out_pix,
    output logic             out_last
);

    logic                    en;
    logic                    b1_valid_reg;
    kemt_tag_t               b1_tag_reg;
    logic [7:0][RESP_W-1:0]  b1_resp_reg;
    logic                    b2_valid_reg;
    kemt_tag_t               b2_tag_reg;
    logic [RESP_W-1:0]       b2_max_reg;
    logic                    b3_valid_reg;
    kemt_tag_t               b3_tag_reg;
    logic [PIX_W-1:0]        b3_val_reg;
    logic [PIX_W-1:0]        lo_reg;
    logic [PIX_W-1:0]        hi_reg;
    logic                    o_valid_reg;
    logic [PIX_W-1:0]        o_rdata_reg;
    logic [PIX_W-1:0]        o_thr_reg;
    logic                    o_interior_reg;
    logic                    o_last_reg;
    logic [PIX_W-1:0]        store_mem [STORE_DEPTH];

    logic [SUM_W-1:0]        sum8;
    logic [7:0][RESP_W-1:0]  resp;
    logic [RESP_W-1:0]       max_l1 [4];
    logic [RESP_W-1:0]       max_l2 [2];
    logic [RESP_W-1:0]       max_all;
    logic [PROD_W-1:0]       prod;
    logic [PIX_W-1:0]        lo_base;
    logic [PIX_W-1:0]        hi_base;
    logic [PIX_W:0]          mid_sum;
    logic                    b3_store;

    assign en  = !(o_valid_reg && !out_ready);
    assign pop = en && !qstat.empty;

    always_comb
    begin
        logic [SUM_W-1:0]  three;
        logic [SUM_W-1:0]  five;
        logic [RESP_W-1:0] a;
        logic [RESP_W-1:0] b;
        sum8 = '0;
        for (int i = 0; i < 8; i++)
        begin
            sum8 = sum8 + SUM_W'(head.nb[i]);
        end
        for (int k = 0; k < 8; k++)
        begin
            three = SUM_W'(head.nb[k]) + SUM_W'(head.nb[(k + 1) % 8])
                    + SUM_W'(head.nb[(k + 7) % 8]);
            five  = sum8 - three;
            a     = RESP_W'(three) * RESP_W'(5);
            b     = RESP_W'(five) * RESP_W'(3);
            resp[k] = (a >= b) ? (a - b) : (b - a);
        end
    end

    always_comb
    begin
        for (int i = 0; i < 4; i++)
        begin
            max_l1[i] = (b1_resp_reg[2*i] > b1_resp_reg[2*i+1]) ?
                        b1_resp_reg[2*i] : b1_resp_reg[2*i+1];
        end
        for (int i = 0; i < 2; i++)
        begin
            max_l2[i] = (max_l1[2*i] > max_l1[2*i+1]) ? max_l1[2*i] : max_l1[2*i+1];
        end
        max_all = (max_l2[0] > max_l2[1]) ? max_l2[0] : max_l2[1];
    end

    assign prod     = PROD_W'(b2_max_reg) * DIV15_MUL;
    assign lo_base  = b3_tag_reg.restart ? BG_VAL : lo_reg;
    assign hi_base  = b3_tag_reg.restart ? EDGE_VAL : hi_reg;
    assign mid_sum  = {1'b0, hi_reg} + {1'b0, lo_reg};
    assign b3_store = b3_valid_reg && (b3_tag_reg.op == OP_LOAD) && b3_tag_reg.calc;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            b1_valid_reg <= 1'b0;
            b2_valid_reg <= 1'b0;
            b3_valid_reg <= 1'b0;
            o_valid_reg  <= 1'b0;
            lo_reg       <= BG_VAL;
            hi_reg       <= EDGE_VAL;
        end
        else if (cfg_we)
        begin
            lo_reg <= BG_VAL;
            hi_reg <= EDGE_VAL;
        end
        else if (en)
        begin
            b1_valid_reg <= !qstat.empty;
            b2_valid_reg <= b1_valid_reg;
            b3_valid_reg <= b2_valid_reg;
            o_valid_reg  <= b3_valid_reg && (b3_tag_reg.op == OP_FETCH);
            if (b3_valid_reg && (b3_tag_reg.op == OP_LOAD))
            begin
                lo_reg <= (b3_tag_reg.calc && (b3_val_reg < lo_base)) ? b3_val_reg : lo_base;
                hi_reg <= (b3_tag_reg.calc && (b3_val_reg > hi_base)) ? b3_val_reg : hi_base;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            b1_tag_reg  <= head.tag;
            b1_resp_reg <= resp;
            b2_tag_reg  <= b1_tag_reg;
            b2_max_reg  <= max_all;
            b3_tag_reg  <= b2_tag_reg;
            b3_val_reg  <= prod[DIV15_SHIFT +: PIX_W];
            o_thr_reg      <= mid_sum[PIX_W:1];
            o_interior_reg <= b3_tag_reg.interior;
            o_last_reg     <= b3_tag_reg.last;
            if (b3_store)
            begin
                store_mem[b3_tag_reg.addr] <= b3_val_reg;
            end
            if (b3_valid_reg && (b3_tag_reg.op == OP_FETCH))
            begin
                o_rdata_reg <= store_mem[b3_tag_reg.addr];
            end
        end
    end

    assign out_valid = o_valid_reg;
    assign out_pix   = (o_interior_reg && (o_rdata_reg >= o_thr_reg)) ? EDGE_VAL : BG_VAL;
    assign out_last  = o_last_reg;

endmodule
